[hdl/bf_token_executor_unit_assert.svh]
// assertion macros shared by the token executor rtl
// depends on a clock named clock and a reset named reset in the including module
`ifndef BF_TOKEN_EXECUTOR_UNIT_ASSERT_SVH
`define BF_TOKEN_EXECUTOR_UNIT_ASSERT_SVH

// checked outside reset
`define BFX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BFX_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/bfx_pkg.sv]
// shared types for the token executor: token kinds and the word formats
// between the top level and the execute logic; no dependencies
package bfx_pkg;

   localparam int KIND_W  = 4;
   localparam int OPER_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_RIGHT = 4'd0,
      KIND_LEFT  = 4'd1,
      KIND_ADD   = 4'd2,
      KIND_SUB   = 4'd3,
      KIND_PUT   = 4'd4,
      KIND_GET   = 4'd5,
      KIND_JZ    = 4'd6,
      KIND_JNZ   = 4'd7,
      KIND_ZERO  = 4'd8
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OPER_W-1:0] operand;
      logic [BYTE_W-1:0] in_byte;
   } token_type;

   typedef struct packed {
      logic               wr_en;
      logic [BYTE_W-1:0]  wr_data;
      logic [INDEX_W-1:0] base;
      logic [BYTE_W-1:0]  out_byte;
      logic               out_valid;
   } exec_type;

endpackage

[hdl/bfx_exec.sv]
// execute logic for one token: new cell value, jump base and emitted byte
// depends on bfx_pkg
module bfx_exec (
   input  bfx_pkg::token_type            tok,
   input  logic [bfx_pkg::BYTE_W-1:0]    cur_byte,
   input  logic [bfx_pkg::INDEX_W-1:0]   token_index,
   output bfx_pkg::exec_type             res
);
   import bfx_pkg::*;

   always_comb begin
      res.wr_en     = 1'b0;
      res.wr_data   = cur_byte;
      res.base      = token_index;
      res.out_byte  = '0;
      res.out_valid = 1'b0;
      case (kind_type'(tok.kind))
         KIND_ADD: begin
            res.wr_en   = 1'b1;
            res.wr_data = cur_byte + tok.operand[BYTE_W-1:0];
         end
         KIND_SUB: begin
            res.wr_en   = 1'b1;
            res.wr_data = cur_byte - tok.operand[BYTE_W-1:0];
         end
         KIND_PUT: begin
            res.out_byte  = cur_byte;
            res.out_valid = 1'b1;
         end
         KIND_GET: begin
            res.wr_en   = 1'b1;
            res.wr_data = tok.in_byte;
         end
         KIND_JZ: begin
            if (cur_byte == '0) res.base = tok.operand;
         end
         KIND_JNZ: begin
            if (cur_byte != '0) res.base = tok.operand;
         end
         KIND_ZERO: begin
            res.wr_en   = 1'b1;
            res.wr_data = '0;
         end
         default: begin
            res.wr_en = 1'b0;
         end
      endcase
   end

endmodule

[hdl/bf_token_executor_unit.sv]
// top level of the run-length token executor: tape memory, data pointer,
// token index and output register; depends on bfx_pkg, bfx_exec and the assert header
//
// Executes one pre-merged tape-machine token per accepted word and returns one
// word per token: the index of the next token and, for a put, the current cell.
// Throughput is one token per clock while neither the rsp side nor the sweep
// stalls it. The data pointer is updated at accept, so the tape read for the
// next token can be issued in the same cycle; the cell is read from a
// single-port-read, single-port-write memory with registered read data,
// modified and written back in the execute stage. A write that lands on the
// cell the following token is reading is forwarded. A result passes from the
// execute stage into an output register and waits there on the rsp side while
// the next token is already executing. After reset the tape is swept to zero,
// one cell per cycle; no token is accepted during that sweep.
// TAPE_CELLS and PROGRAM_DEPTH are powers of two.
`include "bf_token_executor_unit_assert.svh"

module bf_token_executor_unit #(
   parameter int TAPE_CELLS    = 32768,
   parameter int PROGRAM_DEPTH = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bfx_pkg::KIND_W-1:0]    req_kind,
   input  logic [bfx_pkg::OPER_W-1:0]    req_operand,
   input  logic [bfx_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfx_pkg::INDEX_W-1:0]   rsp_next_index,
   output logic [bfx_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_out_valid
);
   import bfx_pkg::*;

   localparam int PTR_W = $clog2(TAPE_CELLS);
   localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);
   // index wrap mask, also keeps the index to sixteen bits
   localparam logic [INDEX_W:0] IDX_MASK =
      (PROGRAM_DEPTH >= 65536) ? (INDEX_W+1)'(17'h0FFFF) : (INDEX_W+1)'(PROGRAM_DEPTH - 1);

   // tape storage, no reset: cleared by the sweep below
   logic [BYTE_W-1:0] tape_mem [TAPE_CELLS];
   logic [BYTE_W-1:0] rdata_ff;

   // clearing sweep
   logic             clearing_ff, clearing_in;
   logic [PTR_W-1:0] clr_addr_ff, clr_addr_in;

   // architectural state
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [INDEX_W-1:0] token_index_ff, token_index_in;

   // execute stage
   logic               s1_valid_ff, s1_valid_in;
   token_type          s1_tok_ff, s1_tok_in;
   logic [PTR_W-1:0]   s1_ptr_ff, s1_ptr_in;
   logic               fwd_ff, fwd_in;
   logic [BYTE_W-1:0]  wr_data_ff, wr_data_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_next_index_ff, rsp_next_index_in;
   logic [BYTE_W-1:0]  rsp_out_byte_ff, rsp_out_byte_in;
   logic               rsp_out_valid_ff, rsp_out_valid_in;

   // handshake and memory control
   logic              req_fire;
   logic              s1_adv;
   logic              s1_write;
   logic [PTR_W-1:0]  step;
   logic [BYTE_W-1:0] cur_byte;
   logic [INDEX_W:0]  next_sum;
   logic [INDEX_W-1:0] next_index;
   logic              mem_we;
   logic [PTR_W-1:0]  mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   token_type         req_tok;
   exec_type          exec_res;

   assign req_tok.kind    = req_kind;
   assign req_tok.operand = req_operand;
   assign req_tok.in_byte = req_in_byte;

   // execute stage moves on when the output register is free or being taken
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_fire  = req_valid && !req_stall;

   // operand modulo tape size: truncate or zero-extend
   assign step = PTR_W'(req_operand);

   // forwarded cell when the previous token wrote the cell just read
   assign cur_byte = fwd_ff ? wr_data_ff : rdata_ff;

   bfx_exec u_exec (
      .tok         (s1_tok_ff),
      .cur_byte    (cur_byte),
      .token_index (token_index_ff),
      .res         (exec_res)
   );

   assign s1_write   = s1_valid_ff && s1_adv && exec_res.wr_en;
   assign next_sum   = {1'b0, exec_res.base} + (INDEX_W+1)'(1);
   assign next_index = INDEX_W'(next_sum & IDX_MASK);

   always_comb begin
      // sweep counter
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + PTR_W'(1);
         if (clr_addr_ff == LAST_CELL) clearing_in = 1'b0;
      end

      // pointer moves at accept so the next read address is ready
      ptr_in = ptr_ff;
      if (req_fire) begin
         case (kind_type'(req_kind))
            KIND_RIGHT: ptr_in = ptr_ff + step;
            KIND_LEFT:  ptr_in = ptr_ff - step;
            default:    ptr_in = ptr_ff;
         endcase
      end

      // token index follows the execute stage
      token_index_in = token_index_ff;
      if (s1_valid_ff && s1_adv) token_index_in = next_index;

      // execute stage load
      s1_valid_in = s1_valid_ff;
      s1_tok_in   = s1_tok_ff;
      s1_ptr_in   = s1_ptr_ff;
      fwd_in      = fwd_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_tok_in   = req_tok;
         s1_ptr_in   = ptr_ff;
         fwd_in      = s1_write && (s1_ptr_ff == ptr_ff);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      // last data written back, used by the forward path
      wr_data_in = wr_data_ff;
      if (s1_write) wr_data_in = exec_res.wr_data;

      // output register
      rsp_valid_in      = rsp_valid_ff;
      rsp_next_index_in = rsp_next_index_ff;
      rsp_out_byte_in   = rsp_out_byte_ff;
      rsp_out_valid_in  = rsp_out_valid_ff;
      if (s1_adv) begin
         rsp_valid_in      = s1_valid_ff;
         rsp_next_index_in = next_index;
         rsp_out_byte_in   = exec_res.out_byte;
         rsp_out_valid_in  = exec_res.out_valid;
      end

      // memory write port: sweep first, then write-back
      mem_we    = clearing_ff || s1_write;
      mem_waddr = clearing_ff ? clr_addr_ff : s1_ptr_ff;
      mem_wdata = clearing_ff ? '0 : exec_res.wr_data;
   end

   // tape memory, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) tape_mem[mem_waddr] <= mem_wdata;
      if (req_fire) rdata_ff <= tape_mem[ptr_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clr_addr_ff    <= '0;
         ptr_ff         <= '0;
         token_index_ff <= '0;
         s1_valid_ff    <= 1'b0;
         fwd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clearing_ff    <= clearing_in;
         clr_addr_ff    <= clr_addr_in;
         ptr_ff         <= ptr_in;
         token_index_ff <= token_index_in;
         s1_valid_ff    <= s1_valid_in;
         fwd_ff         <= fwd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_tok_ff         <= s1_tok_in;
      s1_ptr_ff         <= s1_ptr_in;
      wr_data_ff        <= wr_data_in;
      rsp_next_index_ff <= rsp_next_index_in;
      rsp_out_byte_ff   <= rsp_out_byte_in;
      rsp_out_valid_ff  <= rsp_out_valid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_index = rsp_next_index_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_out_valid  = rsp_out_valid_ff;

   // no token gets in while the tape is being swept
   `BFX_ASSERT_ALWAYS(a_no_accept_in_sweep, clearing_ff |-> req_stall,
      "token accepted during tape sweep")
   // only moves change the data pointer
   `BFX_ASSERT(a_ptr_only_on_move,
      (!req_fire || (req_kind != KIND_RIGHT && req_kind != KIND_LEFT)) |=> $stable(ptr_ff),
      "data pointer changed without a move token")
   // the token index only moves when a token leaves the execute stage
   `BFX_ASSERT(a_index_follows_exec, !(s1_valid_ff && s1_adv) |=> $stable(token_index_ff),
      "token index changed without a completed token")
   // a held execute stage keeps its cell address and forward choice
   `BFX_ASSERT(a_exec_hold, (s1_valid_ff && !s1_adv) |=> ($stable(s1_ptr_ff) && $stable(fwd_ff)),
      "stalled execute stage lost its cell")

endmodule

[tb/sv/tb_bf_token_executor_unit.sv]
// self-checking testbench for bf_token_executor_unit: directed and random tokens with
// random idling on both sides, checked against a cycle-free tape model
// depends on bfx_pkg and the rtl of bf_token_executor_unit
`timescale 1ns / 100ps

module tb_bf_token_executor_unit;
   import bfx_pkg::*;

   localparam int TAPE_CELLS  = 32768;
   localparam int PTR_W       = $clog2(TAPE_CELLS);
   localparam int MAX_WAIT    = 11;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;

   // token codes past the last defined kind; the block only advances the index
   localparam logic [KIND_W-1:0] SPARE_KIND_FIRST = 4'd9;
   localparam logic [KIND_W-1:0] SPARE_KIND_LAST  = 4'd15;

   typedef struct {
      logic [INDEX_W-1:0] next_index;
      logic [BYTE_W-1:0]  out_byte;
      logic               out_valid;
   } token_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind;
   logic [OPER_W-1:0]   req_operand;
   logic [BYTE_W-1:0]   req_in_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [INDEX_W-1:0]  rsp_next_index;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_out_valid;

   // tape machine model state
   logic [BYTE_W-1:0]   tape_model [TAPE_CELLS];
   logic [PTR_W-1:0]    cell_ptr;
   logic [INDEX_W-1:0]  token_idx;

   token_result_type    pending_results [$];
   int                  error_count;
   int                  cycle_count;
   bit                  idle_on;
   bit                  hold_rsp;

   bf_token_executor_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_operand    (req_operand),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_next_index (rsp_next_index),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_valid  (rsp_out_valid)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run guard against a hung simulation
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // executes one token on the model and queues the word it must produce
   task automatic execute_token_model(input logic [KIND_W-1:0] kind,
                                      input logic [OPER_W-1:0] operand,
                                      input logic [BYTE_W-1:0] in_byte);
      logic [BYTE_W-1:0]  cur_byte;
      logic [INDEX_W-1:0] base;
      token_result_type   res;
      cur_byte = tape_model[cell_ptr];
      base = token_idx;
      res.out_byte  = '0;
      res.out_valid = 1'b0;
      case (kind_type'(kind))
         KIND_RIGHT: cell_ptr = cell_ptr + operand[PTR_W-1:0];
         KIND_LEFT:  cell_ptr = cell_ptr - operand[PTR_W-1:0];
         KIND_ADD:   tape_model[cell_ptr] = cur_byte + operand[BYTE_W-1:0];
         KIND_SUB:   tape_model[cell_ptr] = cur_byte - operand[BYTE_W-1:0];
         KIND_PUT: begin
            res.out_byte  = cur_byte;
            res.out_valid = 1'b1;
         end
         KIND_GET:   tape_model[cell_ptr] = in_byte;
         KIND_JZ:    if (cur_byte == '0) base = operand;
         KIND_JNZ:   if (cur_byte != '0) base = operand;
         KIND_ZERO:  tape_model[cell_ptr] = '0;
         default: ;
      endcase
      token_idx = base + 1'b1;
      res.next_index = token_idx;
      pending_results.push_back(res);
   endtask

   // offers one token word; called and returns at a falling edge
   task automatic send_token(input logic [KIND_W-1:0] kind,
                             input logic [OPER_W-1:0] operand,
                             input logic [BYTE_W-1:0] in_byte);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_kind    = kind;
      req_operand = operand;
      req_in_byte = in_byte;
      do @(posedge clock); while (req_stall);
      execute_token_model(kind, operand, in_byte);
      @(negedge clock);
   endtask

   // sender goes quiet until every queued word has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_token();
      int                 pick;
      logic [KIND_W-1:0]  kind;
      logic [OPER_W-1:0]  operand;
      logic [BYTE_W-1:0]  in_byte;
      pick    = $urandom_range(0, 99);
      in_byte = ($urandom_range(0, 5) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
      // moves are mostly short so cells get revisited; now and then a long one
      operand = ($urandom_range(0, 9) == 0) ? OPER_W'($urandom_range(0, 65535))
                                            : OPER_W'($urandom_range(0, 4));
      if (pick < 14)      kind = KIND_RIGHT;
      else if (pick < 28) kind = KIND_LEFT;
      else if (pick < 42) kind = KIND_ADD;
      else if (pick < 54) kind = KIND_SUB;
      else if (pick < 64) kind = KIND_PUT;
      else if (pick < 72) kind = KIND_GET;
      else if (pick < 80) kind = KIND_JZ;
      else if (pick < 88) kind = KIND_JNZ;
      else if (pick < 95) kind = KIND_ZERO;
      else kind = KIND_W'($urandom_range(SPARE_KIND_FIRST, SPARE_KIND_LAST));
      if (kind == KIND_ADD || kind == KIND_SUB || kind == KIND_JZ || kind == KIND_JNZ) begin
         if ($urandom_range(0, 1) == 0) operand = OPER_W'($urandom_range(0, 65535));
         else if ($urandom_range(0, 7) == 0) operand = '1;
      end
      send_token(kind, operand, in_byte);
   endtask

   // extremes of every field, each kind, jump taken and not, index and pointer wrap
   task automatic test_directed();
      send_token(KIND_PUT,   16'd0,     8'h00);
      send_token(KIND_JZ,    16'd65533, 8'hFF);  // taken on a zero cell
      send_token(KIND_JNZ,   16'd100,   8'h00);  // not taken, index reaches the top
      send_token(KIND_RIGHT, 16'd0,     8'h00);  // index wraps to zero
      send_token(KIND_ADD,   16'hFFFF,  8'h00);
      send_token(KIND_PUT,   16'd0,     8'h00);
      send_token(KIND_ADD,   16'd256,   8'h00);  // whole multiple of 256, no change
      send_token(KIND_SUB,   16'hFFFF,  8'h00);
      send_token(KIND_GET,   16'd0,     8'hFF);
      send_token(KIND_JNZ,   16'hFFFF,  8'h00);  // taken, target at the top wraps
      send_token(KIND_SUB,   16'd1,     8'h00);
      send_token(KIND_ZERO,  16'hFFFF,  8'hFF);
      send_token(KIND_JZ,    16'd7,     8'h00);
      send_token(KIND_GET,   16'd0,     8'h00);
      send_token(KIND_RIGHT, 16'hFFFF,  8'h00);  // pointer to the last cell
      send_token(KIND_GET,   16'd0,     8'hA5);
      send_token(KIND_PUT,   16'd0,     8'h00);
      send_token(KIND_RIGHT, 16'd1,     8'h00);  // pointer wraps up to cell zero
      send_token(KIND_LEFT,  16'd1,     8'h00);  // and back down to the last cell
      send_token(KIND_LEFT,  16'hFFFF,  8'h00);
      for (int k = SPARE_KIND_FIRST; k <= SPARE_KIND_LAST; k++)
         send_token(KIND_W'(k), 16'hFFFF, 8'hFF);
   endtask

   task automatic test_random(input int count);
      repeat (count) send_random_token();
   endtask

   task automatic test_no_idling(input int count);
      idle_on = 1'b0;
      repeat (count) send_random_token();
      idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure(input int count);
      idle_on  = 1'b0;
      hold_rsp = 1'b1;
      repeat (count) send_random_token();
      idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_drain_pause(input int count);
      repeat (count) send_random_token();
      wait_drained();
      repeat (count) send_random_token();
   endtask

   // receiver side: random stall before each word, or a long hold on request
   initial begin : rsp_side
      int w;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            w = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            rsp_stall = (w != 0);
            repeat (w) @(negedge clock);
            rsp_stall = 1'b0;
            do @(posedge clock); while (!rsp_valid && !hold_rsp);
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      token_result_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: next_index %0d out_byte %0h out_valid %0b",
                   rsp_next_index, rsp_out_byte, rsp_out_valid);
            error_count++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_next_index !== exp.next_index) begin
               $error("next_index: expected %0d, got %0d", exp.next_index, rsp_next_index);
               error_count++;
            end
            if (rsp_out_byte !== exp.out_byte) begin
               $error("out_byte: expected %0h, got %0h", exp.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_out_valid !== exp.out_valid) begin
               $error("out_valid: expected %0b, got %0b", exp.out_valid, rsp_out_valid);
               error_count++;
            end
         end
      end
   end

   initial begin
      error_count = 0;
      cycle_count = 0;
      idle_on     = 1'b1;
      hold_rsp    = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_kind    = '0;
      req_operand = '0;
      req_in_byte = '0;
      for (int i = 0; i < TAPE_CELLS; i++) tape_model[i] = '0;
      cell_ptr  = '0;
      token_idx = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(1000);
      test_no_idling(100);
      test_backpressure(60);
      test_drain_pause(20);

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
